>>> src/spq_pkg.sv
// shared types and codes for the stable priority queue
`timescale 1ns / 1ps
package spq_pkg;

	localparam int ID_W     = 10;
	localparam int PRIO_W   = 3;
	localparam int MEM_W    = 10;
	localparam int REQ_W    = 2;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	typedef logic [ID_W-1:0]     id_t;
	typedef logic [PRIO_W-1:0]   prio_t;
	typedef logic [MEM_W-1:0]    mem_t;
	typedef logic [REQ_W-1:0]    req_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [OCC_W-1:0]    occ_t;

	localparam req_t REQ_ENQ = 2'd0;
	localparam req_t REQ_DEQ = 2'd1;
	localparam req_t REQ_DEL = 2'd2;
	localparam req_t REQ_CHG = 2'd3;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_EMPTY     = 2'd1;
	localparam status_t ST_NOT_FOUND = 2'd2;
	localparam status_t ST_FULL      = 2'd3;

	typedef struct packed {
		id_t   id;
		prio_t prio;
		mem_t  mem;
	} ent_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_POP  = 2'd2,
		OP_DEL  = 2'd3
	} op_t;

	typedef struct packed {
		op_t  op;
		ent_t ent;
	} cmd_t;

	typedef struct packed {
		logic ins;
		logic hit;
	} link_t;

endpackage

>>> src/spq_req_if.sv
// request channel: valid/ready handshake with the request fields
`timescale 1ns / 1ps
interface spq_req_if;
	logic            valid;
	logic            ready;
	spq_pkg::req_t   req_type;
	spq_pkg::id_t    proc_id;
	spq_pkg::prio_t  priority_req;
	spq_pkg::mem_t   mem_mb;

	modport source (output valid, req_type, proc_id, priority_req, mem_mb, input ready);
	modport sink   (input valid, req_type, proc_id, priority_req, mem_mb, output ready);
endinterface

>>> src/spq_rsp_if.sv
// response channel: valid/ready handshake with the result fields
`timescale 1ns / 1ps
interface spq_rsp_if;
	logic              valid;
	logic              ready;
	spq_pkg::status_t  status;
	spq_pkg::id_t      out_id;
	spq_pkg::prio_t    out_priority;
	spq_pkg::mem_t     out_mem;
	spq_pkg::occ_t     occupancy;

	modport source (output valid, status, out_id, out_priority, out_mem, occupancy, input ready);
	modport sink   (input valid, status, out_id, out_priority, out_mem, occupancy, output ready);
endinterface

>>> src/spq_cell.sv
// one slot of the sorted queue, shifting entries to and from its neighbors
`timescale 1ns / 1ps
module spq_cell (
	input  logic           clk,
	input  spq_pkg::op_t   op,
	input  spq_pkg::ent_t  new_ent,
	input  logic           occ,
	input  spq_pkg::link_t link_in,
	input  spq_pkg::ent_t  left,
	input  spq_pkg::ent_t  right,
	output spq_pkg::ent_t  ent,
	output spq_pkg::link_t link_out,
	output logic           sel
);

	spq_pkg::ent_t ent_q;
	logic          le;
	logic          match;

	assign le       = occ && (ent_q.prio <= new_ent.prio);
	assign match    = occ && (ent_q.id == new_ent.id);
	assign sel      = match && !link_in.hit;
	assign ent      = ent_q;
	assign link_out = '{ins: le, hit: link_in.hit || match};

	always_ff @(posedge clk) begin
		case (op)
			spq_pkg::OP_INS: begin
				if (!le) begin
					if (link_in.ins) begin
						ent_q <= new_ent;
					end else begin
						ent_q <= left;
					end
				end
			end
			spq_pkg::OP_POP: begin
				ent_q <= right;
			end
			spq_pkg::OP_DEL: begin
				if (link_in.hit || match) begin
					ent_q <= right;
				end
			end
			default: begin
				ent_q <= ent_q;
			end
		endcase
	end

endmodule

>>> src/stable_priority_queue_top.sv
// stable priority queue top level: request decode, cell chain and response register
//
// channel | dir | fields
// --------+-----+---------------------------------------------------
// req     | in  | req_type, proc_id, priority_req, mem_mb
// rsp     | out | status, out_id, out_priority, out_mem, occupancy
//
// enqueue, dequeue and remove go through the cell chain from the idle state; change priority
// also passes the S_REINS state (remove, then reinsert through the same chain)
// one response item per request, registered; a request is taken while no response is held or
// while the previous one is being taken, but not in S_REINS, and req stalls while rsp is held
// reset clears the fill count, the state register and the response valid flag only
`timescale 1ns / 1ps
module stable_priority_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic         clk,
	input logic         arst_n,
	spq_req_if.sink     req,
	spq_rsp_if.source   rsp
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_REINS = 2'b10
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	spq_pkg::ent_t       reins_q;
	logic                rsp_valid_q;
	spq_pkg::status_t    status_q;
	spq_pkg::ent_t       out_q;
	spq_pkg::occ_t       occ_q;

	spq_pkg::op_t        cmd_op;
	spq_pkg::ent_t       cmd_ent;
	logic                fire;
	logic                found;
	logic                full;
	logic                empty;
	spq_pkg::ent_t       in_ent;
	spq_pkg::ent_t       sel_ent;
	spq_pkg::status_t    status_d;
	spq_pkg::ent_t       out_d;
	logic [CNT_W-1:0]    occ_d;
	logic                go_reins;
	logic [CNT_W+4:0]    occ_ext;

	logic                occ   [QUEUE_DEPTH];
	logic                sel   [QUEUE_DEPTH];
	spq_pkg::ent_t       ent_w [QUEUE_DEPTH];
	spq_pkg::link_t      link_w[QUEUE_DEPTH+1];

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign fire      = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign in_ent    = '{id: req.proc_id, prio: req.priority_req, mem: req.mem_mb};
	assign cmd_ent   = (state_q == S_REINS) ? reins_q : in_ent;
	assign found     = link_w[QUEUE_DEPTH].hit;
	assign link_w[0] = '{ins: 1'b1, hit: 1'b0};

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			occ[i] = (CNT_W'(i) < count_q);
		end
	end

	always_comb begin
		sel_ent = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (sel[i]) begin
				sel_ent = sel_ent | ent_w[i];
			end
		end
	end

	always_comb begin
		cmd_op   = spq_pkg::OP_HOLD;
		count_d  = count_q;
		status_d = spq_pkg::ST_OK;
		out_d    = '0;
		occ_d    = count_q;
		go_reins = 1'b0;
		if (state_q == S_REINS) begin
			cmd_op  = spq_pkg::OP_INS;
			count_d = count_q + 1'b1;
		end else if (fire) begin
			if (req.req_type == spq_pkg::REQ_ENQ) begin
				if (full) begin
					status_d = spq_pkg::ST_FULL;
				end else begin
					cmd_op  = spq_pkg::OP_INS;
					count_d = count_q + 1'b1;
					out_d   = in_ent;
				end
			end else if (empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else if (req.req_type == spq_pkg::REQ_DEQ) begin
				cmd_op  = spq_pkg::OP_POP;
				count_d = count_q - 1'b1;
				out_d   = ent_w[0];
			end else if (!found) begin
				status_d = spq_pkg::ST_NOT_FOUND;
			end else begin
				cmd_op  = spq_pkg::OP_DEL;
				count_d = count_q - 1'b1;
				out_d   = '{id: req.proc_id, prio: sel_ent.prio, mem: sel_ent.mem};
				if (req.req_type == spq_pkg::REQ_CHG) begin
					out_d.prio = req.priority_req;
					go_reins   = 1'b1;
				end
			end
			occ_d = go_reins ? count_q : count_d;
		end
	end

	assign occ_ext = (CNT_W+5)'(occ_d);

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		spq_cell u_cell (
			.clk      (clk),
			.op       (cmd_op),
			.new_ent  (cmd_ent),
			.occ      (occ[g]),
			.link_in  (link_w[g]),
			.left     (ent_w[(g == 0) ? 0 : g-1]),
			.right    (ent_w[(g == QUEUE_DEPTH-1) ? g : g+1]),
			.ent      (ent_w[g]),
			.link_out (link_w[g+1]),
			.sel      (sel[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			unique case (state_q)
				S_IDLE: begin
					if (go_reins) begin
						state_q <= S_REINS;
					end
				end
				S_REINS: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			out_q    <= out_d;
			occ_q    <= occ_ext[4:0];
		end
		if (go_reins) begin
			reins_q <= '{id: req.proc_id, prio: req.priority_req, mem: sel_ent.mem};
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.out_id       = out_q.id;
	assign rsp.out_priority = out_q.prio;
	assign rsp.out_mem      = out_q.mem;
	assign rsp.occupancy    = occ_q;

endmodule

>>> src/spq_checker.sv
// port-level checks on the response channel of the stable priority queue
`timescale 1ns / 1ps
module spq_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input spq_pkg::status_t  status,
	input spq_pkg::id_t      out_id,
	input spq_pkg::prio_t    out_priority,
	input spq_pkg::mem_t     out_mem,
	input spq_pkg::occ_t     occupancy
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W+4:0] FULL_EXT = (CNT_W+5)'(QUEUE_DEPTH);

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != spq_pkg::ST_OK)
			|-> (out_id == '0) && (out_priority == '0) && (out_mem == '0))
		else $error("failed request carries entry data");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == spq_pkg::ST_FULL) |-> occupancy == FULL_EXT[4:0])
		else $error("full status without a full queue");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == spq_pkg::ST_EMPTY) |-> occupancy == '0)
		else $error("empty status with entries held");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_id)
			&& $stable(out_priority) && $stable(out_mem) && $stable(occupancy))
		else $error("stalled response item changed");

endmodule

bind stable_priority_queue_top spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.out_id       (rsp.out_id),
	.out_priority (rsp.out_priority),
	.out_mem      (rsp.out_mem),
	.occupancy    (rsp.occupancy)
);

>>> dv/tb_stable_priority_queue_top.sv
// testbench for stable_priority_queue_top: directed and random requests checked against a shadow queue
`timescale 1ns / 1ps
module tb_stable_priority_queue_top;
	import spq_pkg::*;

	localparam int DEPTH      = 16;
	localparam int STALL_MAX  = 4000;
	localparam int MAX_SHOWN  = 10;

	typedef struct packed {
		status_t status;
		id_t     id;
		prio_t   prio;
		mem_t    mem;
		occ_t    occ;
	} result_t;

	logic clk;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	stable_priority_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the sorted store
	ent_t shadow_q [DEPTH];
	int   shadow_cnt;

	result_t expected_rsp [$];
	int      mismatches;
	int      send_idle_pct;
	int      rcv_idle_pct;
	int      hold_off;
	int      quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void shadow_drop(int pos);
		for (int i = pos; i + 1 < shadow_cnt; i++) begin
			shadow_q[i] = shadow_q[i + 1];
		end
		shadow_cnt--;
	endfunction

	function automatic void shadow_insert(id_t id, prio_t pr, mem_t mem);
		int pos;
		pos = 0;
		while (pos < shadow_cnt && shadow_q[pos].prio <= pr) pos++;
		for (int i = shadow_cnt; i > pos; i--) begin
			shadow_q[i] = shadow_q[i - 1];
		end
		shadow_q[pos].id   = id;
		shadow_q[pos].prio = pr;
		shadow_q[pos].mem  = mem;
		shadow_cnt++;
	endfunction

	function automatic result_t queue_step(req_t rq, id_t id, prio_t pr, mem_t mem);
		result_t r;
		int      pos;
		mem_t    kept;
		r        = '0;
		r.status = ST_OK;
		if (rq == REQ_ENQ) begin
			if (shadow_cnt >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				shadow_insert(id, pr, mem);
				r.id   = id;
				r.prio = pr;
				r.mem  = mem;
			end
		end else if (shadow_cnt == 0) begin
			r.status = ST_EMPTY;
		end else if (rq == REQ_DEQ) begin
			r.id   = shadow_q[0].id;
			r.prio = shadow_q[0].prio;
			r.mem  = shadow_q[0].mem;
			shadow_drop(0);
		end else begin
			pos = 0;
			while (pos < shadow_cnt && shadow_q[pos].id != id) pos++;
			if (pos >= shadow_cnt) begin
				r.status = ST_NOT_FOUND;
			end else begin
				kept  = shadow_q[pos].mem;
				r.id  = id;
				r.mem = kept;
				if (rq == REQ_DEL) begin
					r.prio = shadow_q[pos].prio;
					shadow_drop(pos);
				end else begin
					shadow_drop(pos);
					shadow_insert(id, pr, kept);
					r.prio = pr;
				end
			end
		end
		r.occ = occ_t'(shadow_cnt);
		return r;
	endfunction

	task automatic send_req(req_t rq, id_t id, prio_t pr, mem_t mem);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= rq;
		req_ch.proc_id      <= id;
		req_ch.priority_req <= pr;
		req_ch.mem_mb       <= mem;
		do @(posedge clk); while (!req_ch.ready);
		expected_rsp.push_back(queue_step(rq, id, pr, mem));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (expected_rsp.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// ids mostly taken from held entries so remove and change hit
	task automatic random_request(int enq_pct);
		req_t  rq;
		id_t   id;
		int    pick;
		pick = $urandom_range(99);
		if (pick < enq_pct) begin
			rq = REQ_ENQ;
		end else begin
			case ($urandom_range(2))
				0: rq = REQ_DEQ;
				1: rq = REQ_DEL;
				default: rq = REQ_CHG;
			endcase
		end
		pick = $urandom_range(99);
		if (shadow_cnt > 0 && pick < 65) begin
			id = shadow_q[$urandom_range(shadow_cnt - 1)].id;
		end else if (pick < 85) begin
			id = id_t'($urandom_range(15));
		end else begin
			id = id_t'($urandom_range(999));
		end
		send_req(rq, id, prio_t'($urandom_range(7)), mem_t'($urandom_range(1023)));
	endtask

	task automatic test_empty_requests();
		send_req(REQ_DEQ, 10'd0, 3'd0, 10'd0);
		send_req(REQ_DEL, 10'd999, 3'd7, 10'd1023);
		send_req(REQ_CHG, 10'd0, 3'd7, 10'd1023);
	endtask

	task automatic test_insert_order();
		send_req(REQ_ENQ, 10'd999, 3'd7, 10'd1023);
		send_req(REQ_ENQ, 10'd0, 3'd0, 10'd0);
		send_req(REQ_ENQ, 10'd12, 3'd3, 10'd512);
		send_req(REQ_ENQ, 10'd34, 3'd3, 10'd1);
		send_req(REQ_ENQ, 10'd12, 3'd5, 10'd7);
	endtask

	task automatic test_remove_and_change();
		send_req(REQ_DEL, 10'd12, 3'd0, 10'd0);
		send_req(REQ_DEL, 10'd500, 3'd0, 10'd0);
		send_req(REQ_CHG, 10'd999, 3'd0, 10'd0);
		send_req(REQ_CHG, 10'd777, 3'd2, 10'd0);
		send_req(REQ_CHG, 10'd34, 3'd7, 10'd0);
		repeat (5) send_req(REQ_DEQ, 10'd0, 3'd0, 10'd0);
		send_req(REQ_DEQ, 10'd0, 3'd0, 10'd0);
	endtask

	task automatic test_random_traffic(int n, int s_pct, int r_pct);
		send_idle_pct = s_pct;
		rcv_idle_pct  = r_pct;
		for (int i = 0; i < n; i++) begin
			random_request(((i / 40) % 2) ? 25 : 85);
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		rcv_idle_pct  = 0;
		hold_off      = 300;
		repeat (40) random_request(85);
		wait_drained();
	endtask

	// receiver side
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_off--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN) begin
					$display("unexpected item: st=%0d id=%0d prio=%0d mem=%0d occ=%0d",
						rsp_ch.status, rsp_ch.out_id, rsp_ch.out_priority,
						rsp_ch.out_mem, rsp_ch.occupancy);
				end
			end else begin
				exp_r = expected_rsp.pop_front();
				if (rsp_ch.status !== exp_r.status || rsp_ch.out_id !== exp_r.id ||
						rsp_ch.out_priority !== exp_r.prio || rsp_ch.out_mem !== exp_r.mem ||
						rsp_ch.occupancy !== exp_r.occ) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN) begin
						$display("mismatch: exp st=%0d id=%0d prio=%0d mem=%0d occ=%0d",
							exp_r.status, exp_r.id, exp_r.prio, exp_r.mem, exp_r.occ);
						$display("          got st=%0d id=%0d prio=%0d mem=%0d occ=%0d",
							rsp_ch.status, rsp_ch.out_id, rsp_ch.out_priority,
							rsp_ch.out_mem, rsp_ch.occupancy);
					end
				end
			end
		end
	end

	// watchdog on cycles with no accepted item
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < STALL_MAX) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("stable_priority_queue_top test failed");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_ENQ;
		req_ch.proc_id      = '0;
		req_ch.priority_req = '0;
		req_ch.mem_mb       = '0;
		shadow_cnt          = 0;
		mismatches          = 0;
		hold_off            = 0;
		send_idle_pct       = 22;
		rcv_idle_pct        = 75;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_requests();
		test_insert_order();
		test_remove_and_change();
		wait_drained();
		test_random_traffic(240, 22, 75);
		wait_drained();
		test_backpressure();
		test_random_traffic(240, 75, 22);
		wait_drained();
		test_random_traffic(240, 0, 0);
		wait_drained();
		repeat (16) @(posedge clk);

		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("stable_priority_queue_top test passed");
		end else begin
			$display("stable_priority_queue_top test failed");
		end
		$finish;
	end
endmodule
